// ===== design/nsab_pkg.sv =====
`default_nettype none
package nsab_pkg;

    localparam int MAX_DIM   = 128;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int DIM_W     = COORD_W + 1;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int PROD_W    = COORD_W + DIM_W;
    localparam int COUNT_W   = 2 * DIM_W;
    localparam int STEP_W    = $clog2(COORD_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 3'd4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DINIT,
        S_DIV,
        S_ADDR,
        S_READ,
        S_PROD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_we;
        logic emit_start;
        logic div_init;
        logic div_step;
        logic addr_load;
        logic read_en;
        logic prod_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/nsab_div.sv =====
`default_nettype none
module nsab_div
    import nsab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_init,
    input  wire logic               i_step,
    input  wire logic [PROD_W-1:0]  i_num,
    input  wire logic [DIM_W-1:0]   i_den,
    output logic      [COORD_W-1:0] o_quo
);

    // quotient is known to fit COORD_W bits, so the top bits seed the remainder
    logic [DIM_W-1:0]   r_rem;
    logic [COORD_W-1:0] r_lo;
    logic [COORD_W-1:0] r_quo;
    logic [DIM_W:0]     trial;
    logic [DIM_W:0]     diff;

    assign trial = {r_rem, r_lo[COORD_W-1]};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= i_num[PROD_W-1:COORD_W];
            r_lo  <= i_num[COORD_W-1:0];
            r_quo <= '0;
        end else if (i_step) begin
            r_lo <= {r_lo[COORD_W-2:0], 1'b0};
            if (trial >= {1'b0, i_den}) begin
                r_rem <= diff[DIM_W-1:0];
                r_quo <= {r_quo[COORD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIM_W-1:0];
                r_quo <= {r_quo[COORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

// ===== design/nsab_ctrl.sv =====
`default_nettype none
module nsab_ctrl
    import nsab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_mode,
    input  wire t_sts i_sts,
    output logic      o_ready,
    output t_cmd      o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_mode == MODE_EMIT) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_DINIT;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(COORD_W - 1)) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr_load = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.read_en = 1'b1;
                n_state       = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod_load = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/nsab_dp.sv =====
`default_nettype none
module nsab_dp
    import nsab_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [31:0]           i_pixel,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_out_ready,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    output logic [15:0]                o_out_color,
    output logic                       o_out_last
);

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [7:0] v);
        if (v == 8'd0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    // v*255/31 = 8v + floor(7v/31); the reciprocal 265/8192 is exact for 7v <= 217
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [7:0]  y;
        logic [16:0] p;
        y = 8'(v) * 8'd7;
        p = 17'(y) * 17'd265;
        return {v, 3'b000} + 8'(p[16:13]);
    endfunction

    // v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] q;
        if (v >= 6'd63) begin
            q = 2'd3;
        end else if (v >= 6'd42) begin
            q = 2'd2;
        end else if (v >= 6'd21) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {v, 2'b00} + 8'(q);
    endfunction

    // floor(x/255) for x <= 255*255
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + 17'd1 + (x >> 8);
        return t[15:8];
    endfunction

    logic [7:0]  r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [15:0] r_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 8'd1;
            r_src_h <= 8'd1;
            r_dst_w <= 8'd1;
            r_dst_h <= 8'd1;
            r_bg    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_W: r_src_w <= i_cfg_data[7:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[7:0];
                CFG_DST_W: r_dst_w <= i_cfg_data[7:0];
                CFG_DST_H: r_dst_h <= i_cfg_data[7:0];
                CFG_BG:    r_bg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] sw, sh, dw, dh;
    assign sw = eff_dim(r_src_w);
    assign sh = eff_dim(r_src_h);
    assign dw = eff_dim(r_dst_w);
    assign dh = eff_dim(r_dst_h);

    // load side
    logic [ADDR_W-1:0]  r_lp;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  lp_eff;
    logic [COUNT_W-1:0] lp_next;

    assign count   = COUNT_W'(sw) * COUNT_W'(sh);
    assign lp_eff  = (COUNT_W'(r_lp) >= count) ? '0 : r_lp;
    assign lp_next = COUNT_W'(lp_eff) + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_cmd.load_we) begin
            r_lp <= (lp_next >= count) ? '0 : lp_next[ADDR_W-1:0];
        end
    end

    // emit position
    logic [COORD_W-1:0] r_col, r_row;
    logic [COORD_W-1:0] col_eff, row_eff;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic               col_wrap, row_wrap;

    assign col_eff  = (DIM_W'(r_col) >= dw) ? '0 : r_col;
    assign row_eff  = (DIM_W'(r_row) >= dh) ? '0 : r_row;
    assign col_inc  = DIM_W'(col_eff) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_eff) + DIM_W'(1);
    assign col_wrap = (col_inc >= dw);
    assign row_wrap = (row_inc >= dh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.emit_start) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_inc[COORD_W-1:0];
            end else begin
                r_col <= col_inc[COORD_W-1:0];
                r_row <= row_eff;
            end
        end
    end

    logic [PROD_W-1:0] r_num_x, r_num_y;
    logic              r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_num_x <= PROD_W'(col_eff) * PROD_W'(sw);
            r_num_y <= PROD_W'(row_eff) * PROD_W'(sh);
            r_last  <= col_wrap && row_wrap;
        end
    end

    logic [COORD_W-1:0] sx, sy;

    nsab_div u_div_x (
        .i_clk  (i_clk),
        .i_init (i_cmd.div_init),
        .i_step (i_cmd.div_step),
        .i_num  (r_num_x),
        .i_den  (dw),
        .o_quo  (sx)
    );

    nsab_div u_div_y (
        .i_clk  (i_clk),
        .i_init (i_cmd.div_init),
        .i_step (i_cmd.div_step),
        .i_num  (r_num_y),
        .i_den  (dh),
        .o_quo  (sy)
    );

    logic [ADDR_W-1:0] r_addr;
    logic [PROD_W-1:0] addr_sum;

    assign addr_sum = PROD_W'(sy) * PROD_W'(sw) + PROD_W'(sx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_load) begin
            r_addr <= addr_sum[ADDR_W-1:0];
        end
    end

    // frame store: alpha, blue, green, red from the top byte down
    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[lp_eff] <= i_pixel;
        end
        if (i_cmd.read_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // blend
    logic [7:0] fg [3];
    logic [7:0] bg8 [3];
    logic [7:0] alpha, inv_alpha;

    assign fg[0]     = r_rd_data[7:0];
    assign fg[1]     = r_rd_data[15:8];
    assign fg[2]     = r_rd_data[23:16];
    assign alpha     = r_rd_data[31:24];
    assign inv_alpha = ALPHA_OPAQUE - alpha;
    assign bg8[0]    = widen5(r_bg[15:11]);
    assign bg8[1]    = widen6(r_bg[10:5]);
    assign bg8[2]    = widen5(r_bg[4:0]);

    logic [15:0] r_fg_prod [3];
    logic [15:0] r_bg_prod [3];
    logic [7:0]  r_fg_raw  [3];
    logic        r_opaque;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_load) begin
            for (int i = 0; i < 3; i++) begin
                r_fg_prod[i] <= 16'(fg[i]) * 16'(alpha);
                r_bg_prod[i] <= 16'(bg8[i]) * 16'(inv_alpha);
                r_fg_raw[i]  <= fg[i];
            end
            r_opaque <= (alpha == ALPHA_OPAQUE);
        end
    end

    logic [7:0] mixed [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mixed[i] = r_opaque ? r_fg_raw[i]
                                : div255(17'(r_fg_prod[i]) + 17'(r_bg_prod[i]));
        end
    end

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_color;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_color <= {mixed[0][7:3], mixed[1][7:2], mixed[2][7:3]};
            r_out_last  <= r_last;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_color    = r_out_color;
    assign o_out_last     = r_out_last;

endmodule
`default_nettype wire

// ===== design/nearest_scale_alpha_blend_rgb565_unit.sv =====
// Nearest-neighbor sprite scaler with alpha blend, RGB565 out.
// Input stream: tuser selects the beat kind (0 load source pixel, 1 emit
// output pixel); tdata carries the RGBA8 source pixel for loads.
// A load beat writes the next source pixel in raster order into the frame
// store and returns no output; the unit stays idle, so loads stream at one
// beat per clock.
// An emit beat returns one RGB565 pixel on the output stream, tlast high on
// the bottom-right pixel of the frame. On the way to output valid, the
// accept edge latches the column and row products for the scaled
// coordinates, then the shift-subtract dividers for the source column and
// row are seeded and run, then come the address, frame-store read, multiply
// and blend/pack stages. The next beat is taken the cycle after the pixel
// reaches the output register, so an emit holds off the input until then.
// A finished pixel waits in the output register; a new beat is still taken
// while it waits, and an emit that finishes before the receiver drains the
// register holds in its last stage.
// Reset clears positions, dimensions (to 1) and the background; the frame
// store is not cleared. Config writes land on the same clock edge.
`default_nettype none
module nearest_scale_alpha_blend_rgb565_unit
    import nsab_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [31:0]           i_s_tdata,   // red, green, blue, alpha
    input  wire logic                  i_s_tuser,   // mode
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // pixel_color
    output logic                       o_m_tlast,   // last_of_frame
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    nsab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_mode  (i_s_tuser),
        .i_sts   (sts),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    nsab_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_s_tdata),
        .i_cmd       (cmd),
        .i_out_ready (i_m_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .o_out_color (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/nsab_chk.sv =====
`default_nettype none
module nsab_chk
    import nsab_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_tvalid,
    input wire logic o_s_tready,
    input wire logic i_s_tuser,
    input wire logic o_m_tvalid,
    input wire logic i_m_tready
);

    logic in_beat;
    assign in_beat = i_s_tvalid && o_s_tready;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat dropped while stalled");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_s_tuser == MODE_EMIT) |=> !o_s_tready)
        else $error("input taken while emit in flight");

    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_s_tuser == MODE_LOAD) && !o_m_tvalid |=> !o_m_tvalid)
        else $error("load beat produced output");

endmodule

bind nearest_scale_alpha_blend_rgb565_unit nsab_chk u_nsab_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import nsab_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 24;
    localparam int IDLE_PCT     = 30;
    localparam int RANDOM_ITEMS = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [15:0] color;
        logic        last;
    } t_out_pixel;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [15:0]           m_tdata;
    wire                   m_tlast;

    // scaler state as seen by the predictor
    logic [31:0] sprite_mem    [MEM_DEPTH];
    bit          sprite_loaded [MEM_DEPTH];
    int          load_ptr = 0;
    int          col_ptr  = 0;
    int          row_ptr  = 0;
    logic [7:0]  reg_sw   = 8'd1;
    logic [7:0]  reg_sh   = 8'd1;
    logic [7:0]  reg_dw   = 8'd1;
    logic [7:0]  reg_dh   = 8'd1;
    logic [15:0] reg_bg   = 16'h0000;

    t_out_pixel awaited_pixels [$];
    int         mismatches  = 0;
    int         n_loads     = 0;
    int         n_emits     = 0;
    int         n_frames    = 0;
    int         cycle_count = 0;
    bit         quiet       = 1'b0;

    nearest_scale_alpha_blend_rgb565_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int eff_dim(logic [7:0] v);
        if (v == 8'd0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [7:0] blend_channel(int c, int a, int bg8);
        return 8'((c * a + bg8 * (255 - a)) / 255);
    endfunction

    function automatic bit next_pixel_loaded();
        int sw, sh, dw, dh, c, r;
        sw = eff_dim(reg_sw);
        sh = eff_dim(reg_sh);
        dw = eff_dim(reg_dw);
        dh = eff_dim(reg_dh);
        c  = (col_ptr >= dw) ? 0 : col_ptr;
        r  = (row_ptr >= dh) ? 0 : row_ptr;
        return sprite_loaded[(r * sh / dh) * sw + c * sw / dw];
    endfunction

    function automatic logic [31:0] random_rgba();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(7))
            0, 1: v[31:24] = 8'hFF;
            2:    v[31:24] = 8'h00;
            3:    v[31:24] = 8'hFE;
            4:    v = '0;
            5:    v = '1;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(129, 255));
            2:       return 16'($urandom_range(9, 128));
            3:       return {8'($urandom()), 8'($urandom_range(1, 8))};
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] pick_bg();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic store_source_pixel(logic [31:0] rgba);
        int count;
        count = eff_dim(reg_sw) * eff_dim(reg_sh);
        if (load_ptr >= count) load_ptr = 0;
        sprite_mem[load_ptr]    = rgba;
        sprite_loaded[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= count) load_ptr = 0;
        n_loads++;
    endtask

    task automatic compute_scaled_pixel();
        int          sw, sh, dw, dh, a;
        logic [31:0] word;
        logic [7:0]  r, g, b;
        t_out_pixel  px;
        sw = eff_dim(reg_sw);
        sh = eff_dim(reg_sh);
        dw = eff_dim(reg_dw);
        dh = eff_dim(reg_dh);
        if (col_ptr >= dw) col_ptr = 0;
        if (row_ptr >= dh) row_ptr = 0;
        word = sprite_mem[(row_ptr * sh / dh) * sw + col_ptr * sw / dw];
        r = word[7:0];
        g = word[15:8];
        b = word[23:16];
        a = int'(word[31:24]);
        if (a < 255) begin
            r = blend_channel(r, a, int'(reg_bg[15:11]) * 255 / 31);
            g = blend_channel(g, a, int'(reg_bg[10:5]) * 255 / 63);
            b = blend_channel(b, a, int'(reg_bg[4:0]) * 255 / 31);
        end
        px.color = {r[7:3], g[7:2], b[7:3]};
        px.last  = (col_ptr == dw - 1) && (row_ptr == dh - 1);
        awaited_pixels.push_back(px);
        col_ptr++;
        if (col_ptr >= dw) begin
            col_ptr = 0;
            row_ptr++;
            if (row_ptr >= dh) row_ptr = 0;
        end
        n_emits++;
    endtask

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("MISMATCH %s: expected %h, got %h", what, want, got);
        mismatches++;
    endtask

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(logic mode, logic [31:0] data);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        if (mode == MODE_LOAD) store_source_pixel(data);
        else compute_scaled_pixel();
    endtask

    task automatic load_sprite(int n);
        repeat (n) send_beat(MODE_LOAD, random_rgba());
    endtask

    task automatic emit_pixels(int n);
        repeat (n) send_beat(MODE_EMIT, $urandom());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SRC_W: reg_sw = data[7:0];
            CFG_SRC_H: reg_sh = data[7:0];
            CFG_DST_W: reg_dw = data[7:0];
            CFG_DST_H: reg_dh = data[7:0];
            CFG_BG:    reg_bg = data;
            default: ;
        endcase
    endtask

    task automatic write_scaler_regs(logic [15:0] sw, logic [15:0] sh, logic [15:0] dw,
                                     logic [15:0] dh, logic [15:0] bg);
        write_reg(CFG_SRC_W, sw);
        write_reg(CFG_SRC_H, sh);
        write_reg(CFG_DST_W, dw);
        write_reg(CFG_DST_H, dh);
        write_reg(CFG_BG, bg);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // opaque, fully transparent, nearly opaque and nearly transparent pixels
    task automatic test_blend_cases();
        write_scaler_regs(16'd2, 16'd2, 16'd4, 16'd2, 16'hF81F);
        send_beat(MODE_LOAD, {8'hFF, 8'h80, 8'h00, 8'hFF});
        send_beat(MODE_LOAD, {8'h00, 8'h56, 8'h34, 8'h12});
        send_beat(MODE_LOAD, {8'hFE, 8'hFF, 8'hFF, 8'h00});
        send_beat(MODE_LOAD, {8'h01, 8'hFF, 8'hFF, 8'hFF});
        emit_pixels(9);
        drain_results();
        write_scaler_regs(16'd2, 16'd2, 16'd2, 16'd2, 16'hFFFF);
        emit_pixels(4);
        drain_results();
        write_scaler_regs(16'd2, 16'd2, 16'd2, 16'd2, 16'h0000);
        emit_pixels(4);
        drain_results();
    endtask

    // zero and oversized dimensions clamp; upper data bits are dropped
    task automatic test_dim_limits();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_scaler_regs(16'h0100, 16'h00FF, 16'h0000, 16'h00C8, 16'h07E0);
        load_sprite(128);
        emit_pixels(130);
        drain_results();
        write_scaler_regs(16'd128, 16'd1, 16'd129, 16'd1, pick_bg());
        load_sprite(128);
        emit_pixels(128);
        drain_results();
    endtask

    // load pointer wraps past the sprite, then restarts when the sprite shrinks
    task automatic test_load_wrap();
        write_scaler_regs(16'd3, 16'd2, 16'd5, 16'd4, pick_bg());
        load_sprite(10);
        emit_pixels(21);
        drain_results();
        write_scaler_regs(16'd2, 16'd1, 16'd3, 16'd1, pick_bg());
        load_sprite(3);
        emit_pixels(4);
        drain_results();
    endtask

    // destination shrinks (then grows in height) while the output position is mid-frame
    task automatic test_emit_resize();
        write_scaler_regs(16'd4, 16'd4, 16'd8, 16'd8, pick_bg());
        load_sprite(16);
        emit_pixels(20);
        drain_results();
        write_scaler_regs(16'd4, 16'd4, 16'd3, 16'd2, pick_bg());
        emit_pixels(8);
        drain_results();
        write_scaler_regs(16'd4, 16'd4, 16'd2, 16'd5, pick_bg());
        emit_pixels(6);
        drain_results();
    endtask

    task automatic test_random_frames();
        int          phase, done, count, n_load;
        logic [15:0] sw, sh, dw, dh;
        phase = 0;
        done  = 0;
        while (done < RANDOM_ITEMS) begin
            sw = pick_dim();
            sh = pick_dim();
            if (eff_dim(sw[7:0]) * eff_dim(sh[7:0]) > 96) sh = 16'd1;
            dw = pick_dim();
            dh = pick_dim();
            if (eff_dim(dw[7:0]) * eff_dim(dh[7:0]) > 64) dh = 16'($urandom_range(1, 2));
            quiet = (phase == 2 || phase == 3);
            write_scaler_regs(sw, sh, dw, dh, pick_bg());
            count  = eff_dim(reg_sw) * eff_dim(reg_sh);
            n_load = (phase % 5 == 4) ? count / 2 : count;
            load_sprite(n_load);
            done += n_load;
            repeat ($urandom_range(16, 40)) begin
                if ($urandom_range(4) != 0 && next_pixel_loaded())
                    send_beat(MODE_EMIT, $urandom());
                else
                    send_beat(MODE_LOAD, random_rgba());
                done++;
            end
            drain_results();
            phase++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk) begin : result_check
        t_out_pixel want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_pixels.size() == 0) begin
                report_mismatch("unexpected pixel beat", 16'h0000, m_tdata);
            end else begin
                want = awaited_pixels.pop_front();
                if (m_tdata !== want.color)
                    report_mismatch("pixel_color", want.color, m_tdata);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_frame", 16'(want.last), 16'(m_tlast));
                if (want.last) n_frames++;
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("nearest_scale_alpha_blend_rgb565_unit test failed");
            $finish;
        end
    end

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_blend_cases();
        test_dim_limits();
        test_load_wrap();
        test_emit_resize();
        test_random_frames();
        drain_results();
        $display("run: %0d source pixels loaded, %0d scaled pixels emitted, %0d frame ends",
                 n_loads, n_emits, n_frames);
        $display("run: clamped sizes, sprite and frame wrap, mid-frame resize, alpha blends");
        if (mismatches == 0) begin
            $display("nearest_scale_alpha_blend_rgb565_unit test passed");
        end else begin
            $display("nearest_scale_alpha_blend_rgb565_unit test failed");
        end
        $finish;
    end

endmodule
